@@ hdl/pev_pkg.sv @@
// Shared types and constants for the pointing error vector block.
package pev_pkg;

  // Direction vectors ahead of normalisation: signed, fraction 14 + coord bits.
  localparam int VEC_W  = 35;
  // Unit vector components, Q1.14.
  localparam int UNIT_W = 16;
  localparam int UNIT_ONE = 16384;

  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef enum logic [1:0] {
    CFG_LOCAL_ORIGIN    = 2'd0,
    CFG_POINTING_VECTOR = 2'd1,
    CFG_TARGET_POINT    = 2'd2
  } cfg_idx_t;

endpackage

@@ hdl/pointing_error_vector.sv @@
// Top level: pose transform, two unit-vector pipelines and the rounded cross product.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  input   | in_rot_00..in_rot_22, in_joint_x/y/z    | start high, busy low
//  result  | out_err_x/y/z, out_*_degenerate         | out_valid strobe, one cycle
//  config  | cfg_we, cfg_addr, cfg_wdata             | write when cfg_we high
//
// A request can be issued every cycle; busy stays low. Each result passes
// through the 32-step square root and 15-step division pipelines inside
// the normalisers. Reset clears only the valid bits and the configuration
// registers. The receiver cannot stall, so the pipeline always advances.
module pointing_error_vector (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_rot_00,
  input  logic signed [15:0] in_rot_01,
  input  logic signed [15:0] in_rot_02,
  input  logic signed [15:0] in_rot_10,
  input  logic signed [15:0] in_rot_11,
  input  logic signed [15:0] in_rot_12,
  input  logic signed [15:0] in_rot_20,
  input  logic signed [15:0] in_rot_21,
  input  logic signed [15:0] in_rot_22,
  input  logic signed [15:0] in_joint_x,
  input  logic signed [15:0] in_joint_y,
  input  logic signed [15:0] in_joint_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [47:0]        cfg_wdata,
  output logic               out_valid,
  output logic signed [15:0] out_err_x,
  output logic signed [15:0] out_err_y,
  output logic signed [15:0] out_err_z,
  output logic               out_pointing_degenerate,
  output logic               out_target_degenerate
);

  assign busy = 1'b0;

  // Configuration registers
  logic [47:0] local_origin_r;
  logic [47:0] pointing_vector_r;
  logic [47:0] target_point_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_origin_r    <= '0;
      pointing_vector_r <= '0;
      target_point_r    <= '0;
    end else if (cfg_we) begin
      unique case (pev_pkg::cfg_idx_t'(cfg_addr))
        pev_pkg::CFG_LOCAL_ORIGIN:    local_origin_r    <= cfg_wdata;
        pev_pkg::CFG_POINTING_VECTOR: pointing_vector_r <= cfg_wdata;
        pev_pkg::CFG_TARGET_POINT:    target_point_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage 0: capture request
  logic               s0_v_r;
  logic signed [15:0] s0_rot_r [9];
  logic signed [15:0] s0_joint_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_rot_r[0]   <= in_rot_00;
    s0_rot_r[1]   <= in_rot_01;
    s0_rot_r[2]   <= in_rot_02;
    s0_rot_r[3]   <= in_rot_10;
    s0_rot_r[4]   <= in_rot_11;
    s0_rot_r[5]   <= in_rot_12;
    s0_rot_r[6]   <= in_rot_20;
    s0_rot_r[7]   <= in_rot_21;
    s0_rot_r[8]   <= in_rot_22;
    s0_joint_r[0] <= in_joint_x;
    s0_joint_r[1] <= in_joint_y;
    s0_joint_r[2] <= in_joint_z;
  end

  // Stage 1: rotation products
  logic               s1_v_r;
  logic signed [31:0] s1_po_r [9];
  logic signed [31:0] s1_pp_r [9];
  logic signed [15:0] s1_joint_r [3];
  logic signed [15:0] s1_tgt_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_joint_r <= s0_joint_r;
    for (int c = 0; c < 3; c++) begin
      s1_tgt_r[c] <= $signed(target_point_r[16*c +: 16]);
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        s1_po_r[3*r+c] <= s0_rot_r[3*r+c] * $signed(local_origin_r[16*c +: 16]);
        s1_pp_r[3*r+c] <= s0_rot_r[3*r+c] * $signed(pointing_vector_r[16*c +: 16]);
      end
    end
  end

  // Stage 2: world pointing direction and target direction
  logic                 s2_v_r;
  pev_pkg::vec_t [2:0]  s2_dir_p_r;
  pev_pkg::vec_t [2:0]  s2_dir_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      s2_dir_p_r[r] <= pev_pkg::VEC_W'(s1_pp_r[3*r]) + pev_pkg::VEC_W'(s1_pp_r[3*r+1])
                     + pev_pkg::VEC_W'(s1_pp_r[3*r+2]);
      s2_dir_t_r[r] <= (pev_pkg::VEC_W'(s1_tgt_r[r]) <<< 14)
                     - (pev_pkg::VEC_W'(s1_joint_r[r]) <<< 14)
                     - pev_pkg::VEC_W'(s1_po_r[3*r]) - pev_pkg::VEC_W'(s1_po_r[3*r+1])
                     - pev_pkg::VEC_W'(s1_po_r[3*r+2]);
    end
  end

  // Normalisers
  logic                 up_v;
  logic                 ut_v;
  pev_pkg::unit_t [2:0] up;
  pev_pkg::unit_t [2:0] ut;
  logic                 up_zero;
  logic                 ut_zero;

  pev_unit u_norm_p (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_v_r),
    .in_vec    (s2_dir_p_r),
    .out_valid (up_v),
    .out_unit  (up),
    .out_zero  (up_zero)
  );

  pev_unit u_norm_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_v_r),
    .in_vec    (s2_dir_t_r),
    .out_valid (ut_v),
    .out_unit  (ut),
    .out_zero  (ut_zero)
  );

  // Cross stage A: products
  logic               cx_v_r;
  logic               cx_pdeg_r;
  logic               cx_tdeg_r;
  logic signed [31:0] cx_ab_r [3];
  logic signed [31:0] cx_cd_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_v_r <= 1'b0;
    end else begin
      cx_v_r <= up_v && ut_v;
    end
  end

  always_ff @(posedge clk) begin
    cx_pdeg_r  <= up_zero;
    cx_tdeg_r  <= ut_zero;
    cx_ab_r[0] <= ut[1] * up[2];
    cx_cd_r[0] <= ut[2] * up[1];
    cx_ab_r[1] <= ut[2] * up[0];
    cx_cd_r[1] <= ut[0] * up[2];
    cx_ab_r[2] <= ut[0] * up[1];
    cx_cd_r[2] <= ut[1] * up[0];
  end

  // Cross stage B: difference, round to Q1.14, saturate
  logic signed [33:0] diff [3];
  logic signed [19:0] rnd  [3];
  logic signed [15:0] sat  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = 34'(cx_ab_r[i]) - 34'(cx_cd_r[i]) + 34'sd8192;
      rnd[i]  = 20'(diff[i] >>> 14);
      if (rnd[i] > 20'sd16384) begin
        sat[i] = 16'(pev_pkg::UNIT_ONE);
      end else if (rnd[i] < -20'sd16384) begin
        sat[i] = -16'(pev_pkg::UNIT_ONE);
      end else begin
        sat[i] = 16'(rnd[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cx_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_err_x               <= sat[0];
    out_err_y               <= sat[1];
    out_err_z               <= sat[2];
    out_pointing_degenerate <= cx_pdeg_r;
    out_target_degenerate   <= cx_tdeg_r;
  end

endmodule

@@ hdl/pev_unit.sv @@
// Pipelined normaliser: scales a vector to unit length in Q1.14 via square root and division.
module pev_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  pev_pkg::vec_t  [2:0]  in_vec,
  output logic                  out_valid,
  output pev_pkg::unit_t [2:0]  out_unit,
  output logic                  out_zero
);

  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 15;

  // Stage 1: magnitude and sign
  logic        s1_v_r;
  logic [2:0]  s1_neg_r;
  logic [33:0] s1_mag_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_neg_r[i] <= in_vec[i][pev_pkg::VEC_W-1];
      s1_mag_r[i] <= in_vec[i][pev_pkg::VEC_W-1]
                     ? 34'(35'd0 - 35'(in_vec[i])) : 34'(in_vec[i]);
    end
  end

  // Stage 2: leading one of the largest magnitude sets the shift
  logic [33:0] mx;
  logic [5:0]  lead;
  logic        s2_v_r;
  logic [2:0]  s2_neg_r;
  logic [33:0] s2_mag_r [3];
  logic        s2_zero_r;
  logic        s2_right_r;
  logic [4:0]  s2_amt_r;

  always_comb begin
    mx = s1_mag_r[0];
    if (s1_mag_r[1] > mx) mx = s1_mag_r[1];
    if (s1_mag_r[2] > mx) mx = s1_mag_r[2];
    lead = 6'd0;
    for (int b = 0; b < 34; b++) begin
      if (mx[b]) lead = 6'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_neg_r   <= s1_neg_r;
    s2_mag_r   <= s1_mag_r;
    s2_zero_r  <= (mx == 34'd0);
    s2_right_r <= (lead > 6'd30);
    s2_amt_r   <= (lead > 6'd30) ? 5'(lead - 6'd30) : 5'(6'd30 - lead);
  end

  // Stage 3: bring the largest into [2^30, 2^31)
  logic        s3_v_r;
  logic [2:0]  s3_neg_r;
  logic        s3_zero_r;
  logic [30:0] s3_n_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_neg_r  <= s2_neg_r;
    s3_zero_r <= s2_zero_r;
    for (int i = 0; i < 3; i++) begin
      s3_n_r[i] <= s2_right_r ? 31'(s2_mag_r[i] >> s2_amt_r)
                              : 31'({30'd0, s2_mag_r[i]} << s2_amt_r);
    end
  end

  // Stage 4: squares
  logic        s4_v_r;
  logic [2:0]  s4_neg_r;
  logic        s4_zero_r;
  logic [30:0] s4_n_r [3];
  logic [61:0] s4_sq_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_neg_r  <= s3_neg_r;
    s4_zero_r <= s3_zero_r;
    s4_n_r    <= s3_n_r;
    for (int i = 0; i < 3; i++) begin
      s4_sq_r[i] <= 62'(s3_n_r[i]) * 62'(s3_n_r[i]);
    end
  end

  // Stage 5: sum of squares, then one root bit per stage
  logic        sq_v_r    [SQ_STEPS+1];
  logic [2:0]  sq_neg_r  [SQ_STEPS+1];
  logic        sq_zero_r [SQ_STEPS+1];
  logic [30:0] sq_n_r    [SQ_STEPS+1][3];
  logic [63:0] sq_rem_r  [SQ_STEPS+1];
  logic [31:0] sq_root_r [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_neg_r[0]  <= s4_neg_r;
    sq_zero_r[0] <= s4_zero_r;
    sq_n_r[0]    <= s4_n_r;
    sq_rem_r[0]  <= 64'(s4_sq_r[0]) + 64'(s4_sq_r[1]) + 64'(s4_sq_r[2]);
    sq_root_r[0] <= 32'd0;
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam int B = SQ_STEPS - 1 - k;
    logic [65:0] inc;
    logic        take;

    assign inc  = (66'(sq_root_r[k]) << (B + 1)) + (66'(1) << (2 * B));
    assign take = ({2'b00, sq_rem_r[k]} >= inc);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      sq_neg_r[k+1]  <= sq_neg_r[k];
      sq_zero_r[k+1] <= sq_zero_r[k];
      sq_n_r[k+1]    <= sq_n_r[k];
      sq_rem_r[k+1]  <= take ? 64'({2'b00, sq_rem_r[k]} - inc) : sq_rem_r[k];
      sq_root_r[k+1] <= take ? (sq_root_r[k] | (32'd1 << B)) : sq_root_r[k];
    end
  end

  // Numerators with half-divisor rounding, then one quotient bit per stage
  logic        dv_v_r    [DIV_STEPS+1];
  logic [2:0]  dv_neg_r  [DIV_STEPS+1];
  logic        dv_zero_r [DIV_STEPS+1];
  logic [31:0] dv_den_r  [DIV_STEPS+1];
  logic [46:0] dv_rem_r  [DIV_STEPS+1][3];
  logic [14:0] dv_q_r    [DIV_STEPS+1][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= sq_v_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    dv_neg_r[0]  <= sq_neg_r[SQ_STEPS];
    dv_zero_r[0] <= sq_zero_r[SQ_STEPS];
    dv_den_r[0]  <= sq_root_r[SQ_STEPS];
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= (47'(sq_n_r[SQ_STEPS][i]) << 14)
                        + 47'(sq_root_r[SQ_STEPS] >> 1);
      dv_q_r[0][i]   <= 15'd0;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int B = DIV_STEPS - 1 - j;
    logic [46:0] trial;

    assign trial = 47'(dv_den_r[j]) << B;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      dv_neg_r[j+1]  <= dv_neg_r[j];
      dv_zero_r[j+1] <= dv_zero_r[j];
      dv_den_r[j+1]  <= dv_den_r[j];
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_r[j][i] >= trial) begin
          dv_rem_r[j+1][i] <= dv_rem_r[j][i] - trial;
          dv_q_r[j+1][i]   <= dv_q_r[j][i] | (15'd1 << B);
        end else begin
          dv_rem_r[j+1][i] <= dv_rem_r[j][i];
          dv_q_r[j+1][i]   <= dv_q_r[j][i];
        end
      end
    end
  end

  // Output: apply sign, force zero for a zero vector
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    out_zero <= dv_zero_r[DIV_STEPS];
    for (int i = 0; i < 3; i++) begin
      if (dv_zero_r[DIV_STEPS]) begin
        out_unit[i] <= '0;
      end else if (dv_neg_r[DIV_STEPS][i]) begin
        out_unit[i] <= pev_pkg::unit_t'(16'd0 - {1'b0, dv_q_r[DIV_STEPS][i]});
      end else begin
        out_unit[i] <= pev_pkg::unit_t'({1'b0, dv_q_r[DIV_STEPS][i]});
      end
    end
  end

endmodule

@@ tb/tb_pointing_error_vector.sv @@
// Self-checking testbench for the pointing error vector block.
module tb_pointing_error_vector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 60;

  typedef struct packed {
    logic signed [15:0] ex, ey, ez;
    logic pdeg, tdeg;
  } pev_res_t;

  typedef struct {
    logic signed [15:0] r [9];
    logic signed [15:0] j [3];
  } pose_t;

  typedef struct {
    pose_t p;
    logic  known;
    pev_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_rot_00 = '0, in_rot_01 = '0, in_rot_02 = '0;
  logic signed [15:0] in_rot_10 = '0, in_rot_11 = '0, in_rot_12 = '0;
  logic signed [15:0] in_rot_20 = '0, in_rot_21 = '0, in_rot_22 = '0;
  logic signed [15:0] in_joint_x = '0, in_joint_y = '0, in_joint_z = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [47:0] cfg_wdata = '0;
  logic out_valid;
  logic signed [15:0] out_err_x, out_err_y, out_err_z;
  logic out_pointing_degenerate, out_target_degenerate;

  pointing_error_vector uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [47:0] origin_reg, pointer_reg, target_reg;
  pev_res_t    pending_err[$];
  int          fails = 0;
  int          checked = 0;
  int          idle_pct = 0;

  function automatic logic signed [63:0] comp(logic [47:0] v, int i);
    comp = 64'(signed'(v[16*i +: 16]));
  endfunction

  // Scale to [2^30, 2^31), then divide by the root of the sum of squares.
  function automatic logic normalise(input logic signed [63:0] v[3],
                                     output logic signed [63:0] u[3]);
    logic [63:0] m[3];
    logic [63:0] mx, s, r, q;
    logic [127:0] rem, bitv, acc;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      u = '{0, 0, 0};
      return 1'b1;
    end
    while (mx >= 64'h8000_0000) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < 64'h4000_0000) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    rem = s;
    acc = 0;
    bitv = 128'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= acc + bitv) begin
        rem -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    r = acc[63:0];
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 64'd16384 + (r >> 1)) / r;
      u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
    end
    return 1'b0;
  endfunction

  function automatic logic signed [15:0] round_cross(logic signed [63:0] a, b, c, d);
    logic signed [63:0] p;
    p = (a * b - c * d + 8192) >>> 14;
    if (p > pev_pkg::UNIT_ONE) p = pev_pkg::UNIT_ONE;
    if (p < -pev_pkg::UNIT_ONE) p = -pev_pkg::UNIT_ONE;
    return p[15:0];
  endfunction

  function automatic pev_res_t pointing_error(pose_t ps);
    logic signed [63:0] o[3], dp[3], dt[3], ut[3], up[3];
    pev_res_t res;
    for (int i = 0; i < 3; i++) begin
      o[i] = 64'(ps.j[i]) * 16384;
      dp[i] = 0;
      for (int k = 0; k < 3; k++) begin
        o[i] += 64'(ps.r[3*i+k]) * comp(origin_reg, k);
        dp[i] += 64'(ps.r[3*i+k]) * comp(pointer_reg, k);
      end
      dt[i] = comp(target_reg, i) * 16384 - o[i];
    end
    res.pdeg = normalise(dp, up);
    res.tdeg = normalise(dt, ut);
    res.ex = round_cross(ut[1], up[2], ut[2], up[1]);
    res.ey = round_cross(ut[2], up[0], ut[0], up[2]);
    res.ez = round_cross(ut[0], up[1], ut[1], up[0]);
    return res;
  endfunction

  // Write one register and update the model copy, then hold the port idle before returning.
  task automatic write_reg(pev_pkg::cfg_idx_t idx, logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pev_pkg::CFG_LOCAL_ORIGIN:    origin_reg = val;
      pev_pkg::CFG_POINTING_VECTOR: pointer_reg = val;
      pev_pkg::CFG_TARGET_POINT:    target_reg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Issue one request; start stays high across back-to-back requests.
  task automatic send_pose(pose_t ps, logic known, pev_res_t res);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    {in_rot_00, in_rot_01, in_rot_02} <= {ps.r[0], ps.r[1], ps.r[2]};
    {in_rot_10, in_rot_11, in_rot_12} <= {ps.r[3], ps.r[4], ps.r[5]};
    {in_rot_20, in_rot_21, in_rot_22} <= {ps.r[6], ps.r[7], ps.r[8]};
    {in_joint_x, in_joint_y, in_joint_z} <= {ps.j[0], ps.j[1], ps.j[2]};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_err.push_back(known ? res : pointing_error(ps));
  endtask

  task automatic drain();
    while (pending_err.size() != 0) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b0;
    repeat (LATENCY / 4) @(posedge clk);
  endtask

  function automatic pose_t rand_pose(bit nice);
    pose_t ps;
    for (int i = 0; i < 9; i++)
      ps.r[i] = nice ? ((i % 4 == 0) ? 16'sd16384 : 16'($urandom_range(0, 4000) - 2000))
                     : 16'($urandom);
    for (int i = 0; i < 3; i++) ps.j[i] = 16'($urandom);
    return ps;
  endfunction

  function automatic logic [47:0] rand_vec();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      pev_res_t got, want;
      got = '{out_err_x, out_err_y, out_err_z,
              out_pointing_degenerate, out_target_degenerate};
      if (pending_err.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        fails++;
      end else begin
        want = pending_err.pop_front();
        checked++;
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          fails++;
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    pose_t ident;
    pev_res_t zero_deg;
    origin_reg = '0;
    pointer_reg = '0;
    target_reg = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    ident.r = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
    ident.j = '{0, 0, 0};
    // After reset everything is zero: both directions degenerate.
    zero_deg = '{0, 0, 0, 1'b1, 1'b1};
    rows.push_back('{ident, 1'b1, zero_deg});
    row.p = ident;
    row.p.j = '{32767, -32768, 100};
    row.known = 1'b1;
    row.res = '{0, 0, 0, 1'b1, 1'b0};
    rows.push_back(row);
    foreach (rows[i]) send_pose(rows[i].p, rows[i].known, rows[i].res);
    drain();

    write_reg(pev_pkg::CFG_POINTING_VECTOR, {16'sd0, 16'sd0, 16'sd4096});
    write_reg(pev_pkg::CFG_TARGET_POINT, {16'sd0, 16'sd4096, 16'sd0});
    write_reg(pev_pkg::CFG_LOCAL_ORIGIN, '0);
    rows.delete();
    rows.push_back('{ident, 1'b0, zero_deg});
    // Target at the origin point.
    row.p = ident;
    row.p.j = '{0, 4096, 0};
    row.known = 1'b1;
    row.res = '{0, 0, 0, 1'b0, 1'b1};
    rows.push_back(row);
    row.known = 1'b0;
    row.p.r = '{-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, 0};
    row.p.j = '{-32768, 32767, -1};
    rows.push_back(row);
    row.p.r = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
    rows.push_back(row);
    for (int i = 0; i < 12; i++) begin
      row.p = rand_pose(i[0]);
      rows.push_back(row);
    end
    foreach (rows[i]) send_pose(rows[i].p, rows[i].known, rows[i].res);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = ph < 2 ? 21 : (ph < 4 ? 57 : 0);
      case (ph)
        0: begin
          write_reg(pev_pkg::CFG_LOCAL_ORIGIN, {16'sh7fff, 16'sh8000, 16'sh7fff});
          write_reg(pev_pkg::CFG_POINTING_VECTOR, {16'sh8000, 16'sh8000, 16'sh8000});
          write_reg(pev_pkg::CFG_TARGET_POINT, {16'sh8000, 16'sh7fff, 16'sh8000});
        end
        1: begin
          write_reg(pev_pkg::CFG_LOCAL_ORIGIN, 48'hffff_ffff_ffff);
          write_reg(pev_pkg::CFG_POINTING_VECTOR, {16'sd1, 16'sd0, 16'sd0});
          write_reg(pev_pkg::CFG_TARGET_POINT, '0);
        end
        default: begin
          write_reg(pev_pkg::CFG_LOCAL_ORIGIN, rand_vec());
          write_reg(pev_pkg::CFG_POINTING_VECTOR, rand_vec());
          write_reg(pev_pkg::CFG_TARGET_POINT, rand_vec());
        end
      endcase
      for (int n = 0; n < 155; n++)
        send_pose(rand_pose($urandom_range(99) < 70), 1'b0, zero_deg);
      drain();
    end

    $display("Checked %0d results over eight register settings, with and without gaps.",
             checked);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
